[hw/rtl/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

[hw/rtl/c8x_pkg.sv]
// types, codes and constants of the chip-8 execute unit
package c8x_pkg;

    localparam int NUM_V          = 16;
    localparam int STACK_DEPTH_DF = 16;
    localparam int QUEUE_DEPTH_DF = 2;

    localparam logic [11:0] PC_RESET = 12'h200;
    localparam logic [11:0] PC_STEP  = 12'd2;

    typedef enum logic [3:0] {
        GRP_SYS    = 4'h0,
        GRP_JP     = 4'h1,
        GRP_CALL   = 4'h2,
        GRP_SE_KK  = 4'h3,
        GRP_SNE_KK = 4'h4,
        GRP_SE_XY  = 4'h5,
        GRP_LD_KK  = 4'h6,
        GRP_ADD_KK = 4'h7,
        GRP_ALU    = 4'h8,
        GRP_SNE_XY = 4'h9,
        GRP_LD_I   = 4'hA,
        GRP_JP_V0  = 4'hB,
        GRP_RND    = 4'hC,
        GRP_DRW    = 4'hD,
        GRP_KEY    = 4'hE,
        GRP_MISC   = 4'hF
    } grp_t;

    typedef enum logic [3:0] {
        OP_JP,
        OP_CALL,
        OP_SE_KK,
        OP_SNE_KK,
        OP_SE_XY,
        OP_SNE_XY,
        OP_LD_KK,
        OP_ADD_KK,
        OP_ALU,
        OP_LD_I,
        OP_JP_V0,
        OP_RND,
        OP_IGNORE
    } op_t;

    typedef enum logic [3:0] {
        ALU_MOV  = 4'h0,
        ALU_OR   = 4'h1,
        ALU_AND  = 4'h2,
        ALU_XOR  = 4'h3,
        ALU_ADD  = 4'h4,
        ALU_SUB  = 4'h5,
        ALU_SHR  = 4'h6,
        ALU_SUBN = 4'h7,
        ALU_SHL  = 4'hE
    } alu_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_IGNORED  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        op_t         op;
        alu_t        alu;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [7:0]  imm;
        logic [11:0] nnn;
    } item_t;

    typedef struct packed {
        logic [11:0] next_pc;
        status_t     status;
        logic        reg_written;
        logic [3:0]  reg_index;
        logic [7:0]  reg_value;
        logic [11:0] index_value;
        logic        skipped;
    } result_t;

endpackage

[hw/rtl/c8x_front.sv]
// front stage: accepts instruction beats and classifies them
module c8x_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [15:0]     s_instruction,
    input  logic [7:0]      s_random_byte,
    output logic            q_valid,
    input  logic            q_ready,
    output c8x_pkg::item_t  q_item
);
    import c8x_pkg::*;

    logic  vld_reg;
    item_t item_reg;
    item_t item_next;
    grp_t  grp;
    logic [3:0] n;

    assign s_ready = !vld_reg || q_ready;
    assign q_valid = vld_reg;
    assign q_item  = item_reg;
    assign grp     = grp_t'(s_instruction[15:12]);
    assign n       = s_instruction[3:0];

    always_comb begin
        item_next     = '0;
        item_next.x   = s_instruction[11:8];
        item_next.y   = s_instruction[7:4];
        item_next.imm = s_instruction[7:0];
        item_next.nnn = s_instruction[11:0];
        item_next.op  = OP_IGNORE;
        item_next.alu = ALU_MOV;
        unique case (grp)
            GRP_JP:     item_next.op = OP_JP;
            GRP_CALL:   item_next.op = OP_CALL;
            GRP_SE_KK:  item_next.op = OP_SE_KK;
            GRP_SNE_KK: item_next.op = OP_SNE_KK;
            GRP_SE_XY:  item_next.op = OP_SE_XY;
            GRP_SNE_XY: item_next.op = OP_SNE_XY;
            GRP_LD_KK:  item_next.op = OP_LD_KK;
            GRP_ADD_KK: item_next.op = OP_ADD_KK;
            GRP_LD_I:   item_next.op = OP_LD_I;
            GRP_JP_V0: begin
                item_next.op = OP_JP_V0;
                item_next.y  = 4'd0;
            end
            GRP_RND: begin
                item_next.op  = OP_RND;
                item_next.imm = s_random_byte & s_instruction[7:0];
            end
            GRP_ALU: begin
                unique case (n) inside
                    ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD,
                    ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL: begin
                        item_next.op  = OP_ALU;
                        item_next.alu = alu_t'(n);
                    end
                    default: item_next.op = OP_IGNORE;
                endcase
            end
            GRP_SYS, GRP_DRW, GRP_KEY, GRP_MISC: item_next.op = OP_IGNORE;
            default: item_next.op = OP_IGNORE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_ready) begin
            vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

[hw/rtl/c8x_queue.sv]
// short queue of decoded items between front and back
module c8x_queue #(
    parameter int DEPTH = c8x_pkg::QUEUE_DEPTH_DF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  c8x_pkg::item_t  in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output c8x_pkg::item_t  out_item
);
    import c8x_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    item_t         mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          push;
    logic          pop;

    assign in_ready  = (cnt_reg != FULL);
    assign out_valid = (cnt_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[hw/rtl/c8x_back.sv]
// back stage: register read, execute, architectural state and result register
module c8x_back #(
    parameter int STACK_DEPTH = c8x_pkg::STACK_DEPTH_DF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  c8x_pkg::item_t    q_item,
    output logic              m_valid,
    input  logic              m_ready,
    output c8x_pkg::result_t  m_result
);
    import c8x_pkg::*;

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

    logic [7:0]     vmem [NUM_V];
    logic [NUM_V-1:0] vvld_reg;
    logic [11:0]    rstack [STACK_DEPTH];

    logic           r_vld_reg;
    item_t          r_item_reg;
    logic [7:0]     va_reg;
    logic [7:0]     vb_reg;

    logic [11:0]    pc_reg;
    logic [11:0]    idx_reg;
    logic [SPW-1:0] sp_reg;

    logic           out_vld_reg;
    result_t        out_reg;

    logic           fire;
    logic           pop;
    logic [11:0]    pc_inc;
    logic [11:0]    pc_skip;
    logic [11:0]    pc_new;
    logic [11:0]    idx_new;
    status_t        status;
    logic           wr;
    logic [7:0]     wval;
    logic           skip;
    logic           push;

    assign fire     = r_vld_reg && (!out_vld_reg || m_ready);
    assign q_ready  = !r_vld_reg || fire;
    assign pop      = q_valid && q_ready;
    assign m_valid  = out_vld_reg;
    assign m_result = out_reg;

    always_comb begin
        pc_inc  = pc_reg + PC_STEP;
        pc_skip = pc_reg + PC_STEP + PC_STEP;
        pc_new  = pc_inc;
        idx_new = idx_reg;
        status  = ST_OK;
        wr      = 1'b0;
        wval    = 8'd0;
        skip    = 1'b0;
        push    = 1'b0;
        unique case (r_item_reg.op)
            OP_JP:     pc_new = r_item_reg.nnn;
            OP_CALL: begin
                if (sp_reg >= SP_FULL) begin
                    status = ST_OVERFLOW;
                end else begin
                    push   = 1'b1;
                    pc_new = r_item_reg.nnn;
                end
            end
            OP_SE_KK:  skip = (va_reg == r_item_reg.imm);
            OP_SNE_KK: skip = (va_reg != r_item_reg.imm);
            OP_SE_XY:  skip = (va_reg == vb_reg);
            OP_SNE_XY: skip = (va_reg != vb_reg);
            OP_LD_KK, OP_RND: begin
                wr   = 1'b1;
                wval = r_item_reg.imm;
            end
            OP_ADD_KK: begin
                wr   = 1'b1;
                wval = va_reg + r_item_reg.imm;
            end
            OP_ALU: begin
                wr = 1'b1;
                unique case (r_item_reg.alu)
                    ALU_MOV:  wval = vb_reg;
                    ALU_OR:   wval = va_reg | vb_reg;
                    ALU_AND:  wval = va_reg & vb_reg;
                    ALU_XOR:  wval = va_reg ^ vb_reg;
                    ALU_ADD:  wval = va_reg + vb_reg;
                    ALU_SUB:  wval = va_reg - vb_reg;
                    ALU_SHR:  wval = va_reg >> 1;
                    ALU_SUBN: wval = vb_reg - va_reg;
                    ALU_SHL:  wval = va_reg << 1;
                    default:  wval = va_reg;
                endcase
            end
            OP_LD_I:   idx_new = r_item_reg.nnn;
            OP_JP_V0:  pc_new = r_item_reg.nnn + {4'd0, vb_reg};
            OP_IGNORE: status = ST_IGNORED;
            default:   status = ST_IGNORED;
        endcase
        if (skip) begin
            pc_new = pc_skip;
        end
    end

    // state and result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            pc_reg      <= PC_RESET;
            idx_reg     <= '0;
            sp_reg      <= '0;
            vvld_reg    <= '0;
        end else begin
            if (q_ready) begin
                r_vld_reg <= q_valid;
            end
            if (fire) begin
                out_vld_reg <= 1'b1;
                pc_reg      <= pc_new;
                idx_reg     <= idx_new;
                if (push) begin
                    sp_reg <= sp_reg + 1'b1;
                end
                if (wr) begin
                    vvld_reg[r_item_reg.x] <= 1'b1;
                end
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg.next_pc     <= pc_new;
            out_reg.status      <= status;
            out_reg.reg_written <= wr;
            out_reg.reg_index   <= wr ? r_item_reg.x : 4'd0;
            out_reg.reg_value   <= wr ? wval : 8'd0;
            out_reg.index_value <= idx_new;
            out_reg.skipped     <= skip;
        end
    end

    // v register file, write-first on a same-cycle read
    always_ff @(posedge aclk) begin
        if (fire && wr) begin
            vmem[r_item_reg.x] <= wval;
        end
        if (pop) begin
            r_item_reg <= q_item;
            if (fire && wr && (r_item_reg.x == q_item.x)) begin
                va_reg <= wval;
            end else begin
                va_reg <= vvld_reg[q_item.x] ? vmem[q_item.x] : 8'd0;
            end
            if (fire && wr && (r_item_reg.x == q_item.y)) begin
                vb_reg <= wval;
            end else begin
                vb_reg <= vvld_reg[q_item.y] ? vmem[q_item.y] : 8'd0;
            end
        end
    end

    // return stack
    always_ff @(posedge aclk) begin
        if (fire && push) begin
            rstack[sp_reg[SAW-1:0]] <= pc_inc;
        end
    end

endmodule

[hw/rtl/chip8_instruction_execute.sv]
// top level of the chip-8 execute unit
// an instruction passes the front register, the queue, the operand register and the result register
// throughput: one instruction per cycle while m_ready does not stall the result register
// the result register and the 2-entry queue let input and output stall apart
// reset: synchronous active-low; v registers and index cleared, pc 0x200, stack empty
`include "assert_macros.svh"
module chip8_instruction_execute #(
    parameter int STACK_DEPTH = c8x_pkg::STACK_DEPTH_DF,
    parameter int QUEUE_DEPTH = c8x_pkg::QUEUE_DEPTH_DF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_instruction,
    input  logic [7:0]  s_random_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_next_pc,
    output logic [1:0]  m_status,
    output logic        m_reg_written,
    output logic [3:0]  m_reg_index,
    output logic [7:0]  m_reg_value,
    output logic [11:0] m_index_value,
    output logic        m_skipped
);
    import c8x_pkg::*;

    logic    f_valid;
    logic    f_ready;
    item_t   f_item;
    logic    b_valid;
    logic    b_ready;
    item_t   b_item;
    result_t res;

    c8x_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_instruction (s_instruction),
        .s_random_byte (s_random_byte),
        .q_valid       (f_valid),
        .q_ready       (f_ready),
        .q_item        (f_item)
    );

    c8x_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_item  (b_item)
    );

    c8x_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (b_valid),
        .q_ready  (b_ready),
        .q_item   (b_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (res)
    );

    assign m_next_pc     = res.next_pc;
    assign m_status      = res.status;
    assign m_reg_written = res.reg_written;
    assign m_reg_index   = res.reg_index;
    assign m_reg_value   = res.reg_value;
    assign m_index_value = res.index_value;
    assign m_skipped     = res.skipped;

    `ASSERT_IMPLIES(a_no_write_zero, aclk, aresetn, m_valid && !m_reg_written, m_reg_index == 4'd0 && m_reg_value == 8'd0)
    `ASSERT_IMPLIES(a_skip_ok, aclk, aresetn, m_valid && m_skipped, m_status == ST_OK && !m_reg_written)
    `ASSERT_IMPLIES(a_ovf_quiet, aclk, aresetn, m_valid && m_status == ST_OVERFLOW, !m_reg_written && !m_skipped)
    `ASSERT_NEXT(a_queue_flow, aclk, aresetn, f_valid && !f_ready, f_valid)

endmodule
